### sv/ntc_pkg.sv
package ntc_pkg;

    // Field and register widths
    localparam int CHR_W      = 8;
    localparam int CLASS_W    = 4;
    localparam int VALUE_W    = 32;
    localparam int ACC_W      = 31;
    localparam int ACC_WIDE_W = ACC_W + 4;
    localparam int HOUR60_W   = ACC_W + 6;
    localparam int TSUM_W     = HOUR60_W + 1;
    localparam int MIN_W      = 7;
    localparam int MIN_WIDE_W = MIN_W + 4;
    localparam int SMALL_W    = 11;
    localparam int PHASE_W    = 4;
    localparam int MER_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int YEAR_W     = 16;
    localparam int SEP_W      = 8;

    // Saturation limits and range bounds
    localparam logic [ACC_W-1:0] SAT_MAX     = {ACC_W{1'b1}};
    localparam logic [MIN_W-1:0] MINUTE_SAT  = {MIN_W{1'b1}};
    localparam logic [MIN_W-1:0] MINUTE_LAST = MIN_W'(59);
    localparam logic [ACC_W-1:0] DAY_LAST    = ACC_W'(31);
    localparam logic [ACC_W-1:0] HOUR_LAST   = ACC_W'(23);
    localparam logic [ACC_W-1:0] NOON        = ACC_W'(12);
    localparam logic [4:0]       NOON_SMALL  = 5'd12;
    localparam logic [5:0]       MIN_PER_HR  = 6'd60;

    // Configuration reset values
    localparam logic [YEAR_W-1:0] YEAR_BASE_RST = YEAR_W'(1990);
    localparam logic [YEAR_W-1:0] YEAR_SPAN_RST = YEAR_W'(95);
    localparam logic [SEP_W-1:0]  TIME_SEP_RST  = SEP_W'(58);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_SPAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SEP  = 2'd2;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_START      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_INT        = 4'd1;
    localparam logic [PHASE_W-1:0] PH_COMMA      = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DATE       = 4'd3;
    localparam logic [PHASE_W-1:0] PH_MIN_FIRST  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_MIN        = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SUFFIX     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TIME_END   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SIGN_FIRST = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SIGN_DIGIT = 4'd9;
    localparam logic [PHASE_W-1:0] PH_SIGNED_INT = 4'd10;
    localparam logic [PHASE_W-1:0] PH_DEAD       = 4'd11;

    // Token classes
    localparam logic [CLASS_W-1:0] CL_ILLEGAL   = 4'd0;
    localparam logic [CLASS_W-1:0] CL_YEAR      = 4'd1;
    localparam logic [CLASS_W-1:0] CL_DAY       = 4'd2;
    localparam logic [CLASS_W-1:0] CL_NUMBER    = 4'd3;
    localparam logic [CLASS_W-1:0] CL_TIME      = 4'd4;
    localparam logic [CLASS_W-1:0] CL_LONG_TIME = 4'd5;
    localparam logic [CLASS_W-1:0] CL_REPEAT    = 4'd6;
    localparam logic [CLASS_W-1:0] CL_DELTA     = 4'd7;
    localparam logic [CLASS_W-1:0] CL_BACK      = 4'd8;
    localparam logic [CLASS_W-1:0] CL_BACK_ADJ  = 4'd9;
    localparam logic [CLASS_W-1:0] CL_DATE_FORM = 4'd10;

    // Meridiem codes
    localparam logic [MER_W-1:0] MER_NONE = 2'd0;
    localparam logic [MER_W-1:0] MER_AM   = 2'd1;
    localparam logic [MER_W-1:0] MER_PM   = 2'd2;

    // Characters
    localparam logic [CHR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHR_W-1:0] CH_P_UP  = 8'h50;
    localparam logic [CHR_W-1:0] CH_P_LO  = 8'h70;
    localparam logic [CHR_W-1:0] CH_M_UP  = 8'h4D;
    localparam logic [CHR_W-1:0] CH_M_LO  = 8'h6D;
    localparam logic [CHR_W:0]   CH_NONE  = 9'h100;

    // Configuration register contents
    typedef struct packed {
        logic [YEAR_W-1:0] year_base;
        logic [YEAR_W-1:0] year_span;
        logic [SEP_W-1:0]  time_separator;
    } cfg_t;

    // One character step into the parser
    typedef struct packed {
        logic             fire;
        logic             last;
        logic [CHR_W-1:0] chr;
    } step_t;

    // One classified token
    typedef struct packed {
        logic [CLASS_W-1:0]        token_class;
        logic signed [VALUE_W-1:0] token_value;
    } result_t;

    function automatic logic is_digit(input logic [CHR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // acc * 10 + digit, saturated at 2^31-1
    function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [CHR_W-1:0] c);
        logic [ACC_WIDE_W-1:0] wide;
        wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
             + ACC_WIDE_W'(c - CH_0);
        return (wide > {4'b0000, SAT_MAX}) ? SAT_MAX : wide[ACC_W-1:0];
    endfunction

    // Minute accumulate, saturated at 127
    function automatic logic [MIN_W-1:0] acc_minute(input logic [MIN_W-1:0] acc,
                                                    input logic [CHR_W-1:0] c);
        logic [MIN_WIDE_W-1:0] wide;
        wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
             + MIN_WIDE_W'(c - CH_0);
        return (wide > {4'b0000, MINUTE_SAT}) ? MINUTE_SAT : wide[MIN_W-1:0];
    endfunction

    // Sign character that doubles for a given class; repeat has none
    function automatic logic [CHR_W:0] sign_char(input logic [CLASS_W-1:0] cls);
        logic [CHR_W:0] sc;
        case (cls)
            CL_DELTA:    sc = {1'b0, CH_PLUS};
            CL_BACK:     sc = {1'b0, CH_MINUS};
            CL_BACK_ADJ: sc = {1'b0, CH_TILDE};
            default:     sc = CH_NONE;
        endcase
        return sc;
    endfunction

endpackage

### sv/numeric_token_classifier.sv
// Numeric token classifier.
// Characters of one token arrive on the input channel (chr, last_char) under
// in_valid / in_stall; a transfer happens when in_valid is high and in_stall
// is low. The transfer with last_char set closes the token, and one result
// (token_class, token_value) follows on the output channel under out_valid /
// out_stall. Tokens without last_char set produce no result.
// A result passes from the character register to the result register and
// is presented from there; a stall at the output can hold it between the two.
// Throughput: one character per cycle while no token-closing character waits
// on a stalled result, with no gaps between tokens; the character register and
// the result register each hold one entry, and the parser step sets the rate.
// When the receiver stalls, the result waits in the output register with its
// payload held; the next character is still taken, and only a second
// token-closing character waits in the input register until the output
// register frees.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready; writes are meant for idle periods only.
// Reset clears the token state, the pipeline valids and sets the year base to
// 1990, the year span to 95 and the time separator to ':'.
module numeric_token_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ntc_pkg::CHR_W-1:0]           chr,
    input  logic                                last_char,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ntc_pkg::CLASS_W-1:0]         token_class,
    output logic signed [ntc_pkg::VALUE_W-1:0]  token_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                       in_valid_reg;
    logic [ntc_pkg::CHR_W-1:0]  chr_reg;
    logic                       last_reg;
    logic                       advance;
    logic                       out_blocked;
    ntc_pkg::cfg_t              cfg;
    ntc_pkg::step_t             step;
    ntc_pkg::result_t           result;

    // The held character moves on unless it closes a token and the result
    // register is still waiting on the receiver.
    assign advance  = in_valid_reg && !(last_reg && out_blocked);
    assign in_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            chr_reg  <= chr;
            last_reg <= last_char;
        end
    end

    assign step.fire = advance;
    assign step.last = last_reg;
    assign step.chr  = chr_reg;

    ntc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ntc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .result (result)
    );

    ntc_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && last_reg),
        .result      (result),
        .blocked     (out_blocked),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_class (token_class),
        .token_value (token_value)
    );

endmodule

### sv/ntc_cfg.sv
module ntc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ntc_pkg::cfg_t                      cfg
);

    logic [ntc_pkg::YEAR_W-1:0] year_base_reg;
    logic [ntc_pkg::YEAR_W-1:0] year_span_reg;
    logic [ntc_pkg::SEP_W-1:0]  time_sep_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_base_reg <= ntc_pkg::YEAR_BASE_RST;
            year_span_reg <= ntc_pkg::YEAR_SPAN_RST;
            time_sep_reg  <= ntc_pkg::TIME_SEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ntc_pkg::REG_YEAR_BASE: year_base_reg <= cfg_data;
                ntc_pkg::REG_YEAR_SPAN: year_span_reg <= cfg_data;
                ntc_pkg::REG_TIME_SEP:  time_sep_reg  <= cfg_data[ntc_pkg::SEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.year_base      = year_base_reg;
    assign cfg.year_span      = year_span_reg;
    assign cfg.time_separator = time_sep_reg;

endmodule

### sv/ntc_core.sv
module ntc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  ntc_pkg::cfg_t    cfg,
    input  ntc_pkg::step_t   step,
    output ntc_pkg::result_t result
);

    logic [ntc_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [ntc_pkg::ACC_W-1:0]    number_acc_reg, number_acc_next;
    logic [ntc_pkg::ACC_W-1:0]    hour_hold_reg, hour_hold_next;
    logic [ntc_pkg::HOUR60_W-1:0] hour60_reg, hour60_next;
    logic [ntc_pkg::MIN_W-1:0]    minute_acc_reg, minute_acc_next;
    logic [ntc_pkg::MER_W-1:0]    meridiem_reg, meridiem_next;
    logic                         negate_reg, negate_next;
    logic [ntc_pkg::CLASS_W-1:0]  latched_class_reg, latched_class_next;

    logic                         digit;
    logic [ntc_pkg::CHR_W-1:0]    c;
    logic [ntc_pkg::CHR_W-1:0]    digit_val;
    logic [ntc_pkg::HOUR60_W-1:0] number_wide;

    logic [ntc_pkg::VALUE_W-1:0]  number_word;
    logic [ntc_pkg::YEAR_W:0]     year_top;
    logic                         is_year;
    logic                         is_day;
    logic                         hour_in_range;
    logic [4:0]                   hour_adj;
    logic [ntc_pkg::SMALL_W-1:0]  small_minutes;
    logic [ntc_pkg::TSUM_W-1:0]   long_minutes;
    logic [ntc_pkg::ACC_W-1:0]    long_sat;

    assign c           = step.chr;
    assign digit       = ntc_pkg::is_digit(c);
    assign digit_val   = c - ntc_pkg::CH_0;
    assign number_wide = {6'b000000, number_acc_reg};

    // Per-character phase transition and accumulator update.
    always_comb
    begin
        phase_next         = phase_reg;
        number_acc_next    = number_acc_reg;
        hour_hold_next     = hour_hold_reg;
        hour60_next        = hour60_reg;
        minute_acc_next    = minute_acc_reg;
        meridiem_next      = meridiem_reg;
        negate_next        = negate_reg;
        latched_class_next = latched_class_reg;
        unique case (phase_reg)
            ntc_pkg::PH_START:
            begin
                if (digit)
                begin
                    number_acc_next = ntc_pkg::ACC_W'(digit_val);
                    phase_next      = ntc_pkg::PH_INT;
                end
                else if (c == ntc_pkg::CH_STAR)
                begin
                    latched_class_next = ntc_pkg::CL_REPEAT;
                    phase_next         = ntc_pkg::PH_SIGN_DIGIT;
                end
                else if (c == ntc_pkg::CH_PLUS)
                begin
                    latched_class_next = ntc_pkg::CL_DELTA;
                    phase_next         = ntc_pkg::PH_SIGN_FIRST;
                end
                else if (c == ntc_pkg::CH_MINUS)
                begin
                    latched_class_next = ntc_pkg::CL_BACK;
                    phase_next         = ntc_pkg::PH_SIGN_FIRST;
                end
                else if (c == ntc_pkg::CH_TILDE)
                begin
                    latched_class_next = ntc_pkg::CL_BACK_ADJ;
                    phase_next         = ntc_pkg::PH_SIGN_FIRST;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_INT:
            begin
                if (digit)
                begin
                    number_acc_next = ntc_pkg::acc_digit(number_acc_reg, c);
                end
                else if (c == ntc_pkg::CH_MINUS || c == ntc_pkg::CH_SLASH)
                begin
                    phase_next = ntc_pkg::PH_DATE;
                end
                else if (c == ntc_pkg::CH_COMMA)
                begin
                    phase_next = ntc_pkg::PH_COMMA;
                end
                else if (c == ntc_pkg::CH_COLON || c == ntc_pkg::CH_DOT
                         || c == cfg.time_separator)
                begin
                    // Hour times 60 is formed here, off the finishing path.
                    hour_hold_next = number_acc_reg;
                    hour60_next    = (number_wide << 6) - (number_wide << 2);
                    phase_next     = ntc_pkg::PH_MIN_FIRST;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_MIN_FIRST:
            begin
                if (digit)
                begin
                    minute_acc_next = ntc_pkg::MIN_W'(digit_val);
                    phase_next      = ntc_pkg::PH_MIN;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_MIN:
            begin
                if (digit)
                begin
                    minute_acc_next = ntc_pkg::acc_minute(minute_acc_reg, c);
                end
                else if (c == ntc_pkg::CH_A_LO || c == ntc_pkg::CH_A_UP)
                begin
                    meridiem_next = ntc_pkg::MER_AM;
                    phase_next    = ntc_pkg::PH_SUFFIX;
                end
                else if (c == ntc_pkg::CH_P_LO || c == ntc_pkg::CH_P_UP)
                begin
                    meridiem_next = ntc_pkg::MER_PM;
                    phase_next    = ntc_pkg::PH_SUFFIX;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_SUFFIX:
            begin
                if (c == ntc_pkg::CH_M_LO || c == ntc_pkg::CH_M_UP)
                begin
                    phase_next = ntc_pkg::PH_TIME_END;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_SIGN_FIRST:
            begin
                if ({1'b0, c} == ntc_pkg::sign_char(latched_class_reg))
                begin
                    negate_next = 1'b1;
                    phase_next  = ntc_pkg::PH_SIGN_DIGIT;
                end
                else if (digit)
                begin
                    number_acc_next = ntc_pkg::ACC_W'(digit_val);
                    phase_next      = ntc_pkg::PH_SIGNED_INT;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_SIGN_DIGIT:
            begin
                if (digit)
                begin
                    number_acc_next = ntc_pkg::ACC_W'(digit_val);
                    phase_next      = ntc_pkg::PH_SIGNED_INT;
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_SIGNED_INT:
            begin
                if (digit)
                begin
                    number_acc_next = ntc_pkg::acc_digit(number_acc_reg, c);
                end
                else
                begin
                    phase_next = ntc_pkg::PH_DEAD;
                end
            end
            ntc_pkg::PH_TIME_END:
            begin
                phase_next = ntc_pkg::PH_DEAD;
            end
            default:
            begin
                // Comma, date and dead phases swallow the rest of the token.
            end
        endcase
    end

    // Plain number classification against the year window.
    assign number_word = {1'b0, number_acc_next};
    assign year_top    = {1'b0, cfg.year_base} + {1'b0, cfg.year_span};
    assign is_year     = (number_word >= ntc_pkg::VALUE_W'(cfg.year_base))
                      && (number_word <= ntc_pkg::VALUE_W'(year_top));
    assign is_day      = (number_acc_next >= ntc_pkg::ACC_W'(1))
                      && (number_acc_next <= ntc_pkg::DAY_LAST);

    // Clock time with a suffix: the hour is at most 12, so the product is small.
    assign hour_in_range = (hour_hold_reg >= ntc_pkg::ACC_W'(1))
                        && (hour_hold_reg <= ntc_pkg::NOON);

    always_comb
    begin
        hour_adj = {1'b0, hour_hold_reg[3:0]};
        if (meridiem_next == ntc_pkg::MER_AM && hour_adj == ntc_pkg::NOON_SMALL)
        begin
            hour_adj = 5'd0;
        end
        else if (meridiem_next == ntc_pkg::MER_PM && hour_adj < ntc_pkg::NOON_SMALL)
        begin
            hour_adj = hour_adj + ntc_pkg::NOON_SMALL;
        end
    end

    assign small_minutes = ntc_pkg::SMALL_W'(hour_adj) * ntc_pkg::SMALL_W'(ntc_pkg::MIN_PER_HR)
                         + ntc_pkg::SMALL_W'(minute_acc_next);

    // Clock time without a suffix: hour*60 was precomputed, add and saturate.
    assign long_minutes = {1'b0, hour60_reg} + ntc_pkg::TSUM_W'(minute_acc_next);
    assign long_sat     = (long_minutes > ntc_pkg::TSUM_W'(ntc_pkg::SAT_MAX))
                        ? ntc_pkg::SAT_MAX : long_minutes[ntc_pkg::ACC_W-1:0];

    // Token result as seen after this character.
    always_comb
    begin
        result.token_class = ntc_pkg::CL_ILLEGAL;
        result.token_value = '0;
        if (phase_next == ntc_pkg::PH_INT || phase_next == ntc_pkg::PH_COMMA)
        begin
            if (is_year)
            begin
                result.token_class = ntc_pkg::CL_YEAR;
            end
            else if (is_day)
            begin
                result.token_class = ntc_pkg::CL_DAY;
            end
            else
            begin
                result.token_class = ntc_pkg::CL_NUMBER;
            end
            result.token_value = number_word;
        end
        else if (phase_next == ntc_pkg::PH_DATE)
        begin
            result.token_class = ntc_pkg::CL_DATE_FORM;
        end
        else if (phase_next == ntc_pkg::PH_MIN || phase_next == ntc_pkg::PH_SUFFIX
                 || phase_next == ntc_pkg::PH_TIME_END)
        begin
            if (minute_acc_next <= ntc_pkg::MINUTE_LAST)
            begin
                if (meridiem_next != ntc_pkg::MER_NONE)
                begin
                    if (hour_in_range)
                    begin
                        result.token_class = ntc_pkg::CL_TIME;
                        result.token_value = ntc_pkg::VALUE_W'(small_minutes);
                    end
                end
                else
                begin
                    result.token_class = (hour_hold_reg <= ntc_pkg::HOUR_LAST)
                                       ? ntc_pkg::CL_TIME : ntc_pkg::CL_LONG_TIME;
                    result.token_value = {1'b0, long_sat};
                end
            end
        end
        else if (phase_next == ntc_pkg::PH_SIGNED_INT)
        begin
            result.token_class = latched_class_reg;
            result.token_value = negate_reg ? (-number_word) : number_word;
        end
    end

    // Token state; the last character returns it to the start of a token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ntc_pkg::PH_START;
            number_acc_reg    <= '0;
            hour_hold_reg     <= '0;
            hour60_reg        <= '0;
            minute_acc_reg    <= '0;
            meridiem_reg      <= ntc_pkg::MER_NONE;
            negate_reg        <= 1'b0;
            latched_class_reg <= ntc_pkg::CL_ILLEGAL;
        end
        else if (step.fire)
        begin
            if (step.last)
            begin
                phase_reg         <= ntc_pkg::PH_START;
                number_acc_reg    <= '0;
                hour_hold_reg     <= '0;
                hour60_reg        <= '0;
                minute_acc_reg    <= '0;
                meridiem_reg      <= ntc_pkg::MER_NONE;
                negate_reg        <= 1'b0;
                latched_class_reg <= ntc_pkg::CL_ILLEGAL;
            end
            else
            begin
                phase_reg         <= phase_next;
                number_acc_reg    <= number_acc_next;
                hour_hold_reg     <= hour_hold_next;
                hour60_reg        <= hour60_next;
                minute_acc_reg    <= minute_acc_next;
                meridiem_reg      <= meridiem_next;
                negate_reg        <= negate_next;
                latched_class_reg <= latched_class_next;
            end
        end
    end

endmodule

### sv/ntc_out.sv
module ntc_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  ntc_pkg::result_t                    result,
    output logic                                blocked,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ntc_pkg::CLASS_W-1:0]         token_class,
    output logic signed [ntc_pkg::VALUE_W-1:0]  token_value
);

    logic             out_valid_reg;
    ntc_pkg::result_t result_reg;

    // The register cannot take a new result while a stalled one waits.
    assign blocked = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled since load is never raised then.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign token_class = result_reg.token_class;
    assign token_value = result_reg.token_value;

endmodule

### sv/ntc_checker.sv
module ntc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                last_char,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [ntc_pkg::CLASS_W-1:0]         token_class,
    input logic signed [ntc_pkg::VALUE_W-1:0]  token_value
);

    // A stalled result stays presented.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A new result only follows a transfer that closed a token.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last_char, 2))
        else $error("result without a closing character");

    // Only defined class codes are produced.
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_class <= ntc_pkg::CL_DATE_FORM)
        else $error("undefined token class");

    // Illegal and date-form tokens carry a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_class == ntc_pkg::CL_ILLEGAL
                      || token_class == ntc_pkg::CL_DATE_FORM)
        |-> token_value == '0)
        else $error("nonzero value on illegal or date-form token");

endmodule

bind numeric_token_classifier ntc_checker u_ntc_checker (.*);
